/* sv/lssr_pkg.sv */
// ----------------------------------------------------------------------------
// lssr_pkg
// Shared types, sizes and codes for the LIFO stack with search and reverse.
// ----------------------------------------------------------------------------
package lssr_pkg;

    localparam int DEPTH = 64;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int EW    = 7;

    localparam logic [2:0] OP_PUSH    = 3'd0;
    localparam logic [2:0] OP_POP     = 3'd1;
    localparam logic [2:0] OP_PEEK    = 3'd2;
    localparam logic [2:0] OP_SEARCH  = 3'd3;
    localparam logic [2:0] OP_REVERSE = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic        [2:0]  func;
        logic signed [31:0] value;
    } t_request;

    typedef struct packed {
        logic signed [31:0]   data;
        logic                 found;
        logic        [1:0]    status;
        logic        [EW-1:0] entries;
    } t_result;

    // Count as shown on the result: low bits only when the count is wider.
    function automatic logic [EW-1:0] to_entries(input logic [CW-1:0] count);
        logic [CW+EW-1:0] wide;
        wide = {{EW{1'b0}}, count};
        return wide[EW-1:0];
    endfunction

endpackage

/* sv/lifo_stack_search_reverse.sv */
// ----------------------------------------------------------------------------
// lifo_stack_search_reverse
// LIFO store of signed 32-bit words with push, pop, peek, search and reverse.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake           payload
//  request   in         i_valid / o_ready   i_req  (t_request: func, value)
//  result    out        o_valid / i_ready   o_res  (t_result)
//
//  One request at a time; o_ready is high only when the sequencer is idle
//  and the result register is empty. Push, refused and ignored requests
//  are answered from idle; pop and peek wait on a registered memory read;
//  search compares entries from the bottom up and stops at a match; reverse
//  reads both ends of each pair at once and writes them back in turn through
//  the single write port of the word memory. Reset is synchronous, active
//  low, and clears only the count and control; the memory needs no clearing.
//  A stalled result holds in o_res.
module lifo_stack_search_reverse
    import lssr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_request i_req,
    output logic     o_valid,
    input  logic     i_ready,
    output t_result  o_res
);

    // sequencer codes
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_RD_WAIT  = 3'd1;
    localparam logic [2:0] S_SRCH_RD  = 3'd2;
    localparam logic [2:0] S_SRCH_CMP = 3'd3;
    localparam logic [2:0] S_REV_RD   = 3'd4;
    localparam logic [2:0] S_REV_WLO  = 3'd5;
    localparam logic [2:0] S_REV_WHI  = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_hi, n_hi;
    logic signed [31:0] r_key, n_key;
    t_result           r_out, n_out;
    logic              r_out_valid, n_out_valid;

    // word memory: one write port, two registered read ports
    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd_a, r_rd_b;
    logic               mem_we, mem_re_a, mem_re_b;
    logic [AW-1:0]      mem_waddr, mem_addr_a, mem_addr_b;
    logic signed [31:0] mem_wdata;

    logic          accept;
    logic [CW-1:0] count_dec;
    logic [AW:0]   idx_plus2;

    assign o_ready   = (r_state == S_IDLE) && !r_out_valid;
    assign accept    = i_valid && o_ready;
    assign o_valid   = r_out_valid;
    assign o_res     = r_out;
    assign count_dec = r_count - CW'(1);
    assign idx_plus2 = {1'b0, r_idx} + (AW + 1)'(2);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_hi        = r_hi;
        n_key       = r_key;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = r_rd_a;
        mem_re_a    = 1'b0;
        mem_re_b    = 1'b0;
        mem_addr_a  = r_idx;
        mem_addr_b  = r_hi;

        // drop the result once taken
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // default result: ok, nothing found, count unchanged
                    n_out.data    = '0;
                    n_out.found   = 1'b0;
                    n_out.status  = ST_OK;
                    n_out.entries = to_entries(r_count);
                    n_out_valid   = 1'b1;
                    case (i_req.func)
                        OP_PUSH: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_out.status = ST_FULL;
                            end else begin
                                mem_we        = 1'b1;
                                mem_waddr     = r_count[AW-1:0];
                                mem_wdata     = i_req.value;
                                n_count       = r_count + CW'(1);
                                n_out.entries = to_entries(r_count + CW'(1));
                            end
                        end
                        OP_POP, OP_PEEK: begin
                            if (r_count == '0) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                // hold the result until the top word arrives
                                mem_re_a    = 1'b1;
                                mem_addr_a  = count_dec[AW-1:0];
                                n_out_valid = 1'b0;
                                n_state     = S_RD_WAIT;
                                if (i_req.func == OP_POP) begin
                                    n_count = count_dec;
                                end
                            end
                        end
                        OP_SEARCH: begin
                            if (r_count != '0) begin
                                n_key       = i_req.value;
                                n_idx       = '0;
                                n_out_valid = 1'b0;
                                n_state     = S_SRCH_RD;
                            end
                        end
                        OP_REVERSE: begin
                            if (r_count > CW'(1)) begin
                                n_idx       = '0;
                                n_hi        = count_dec[AW-1:0];
                                n_out_valid = 1'b0;
                                n_state     = S_REV_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD_WAIT: begin
                n_out.data    = r_rd_a;
                n_out.found   = 1'b0;
                n_out.status  = ST_OK;
                n_out.entries = to_entries(r_count);
                n_out_valid   = 1'b1;
                n_state       = S_IDLE;
            end
            S_SRCH_RD: begin
                mem_re_a = 1'b1;
                n_state  = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                n_out.data    = '0;
                n_out.status  = ST_OK;
                n_out.entries = to_entries(r_count);
                n_out.found   = 1'b0;
                if (r_rd_a == r_key) begin
                    n_out.found = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else if (CW'(r_idx) + CW'(1) == r_count) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_SRCH_RD;
                end
            end
            S_REV_RD: begin
                // fetch both ends of the pair at once
                mem_re_a = 1'b1;
                mem_re_b = 1'b1;
                n_state  = S_REV_WLO;
            end
            S_REV_WLO: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = r_rd_b;
                n_state   = S_REV_WHI;
            end
            S_REV_WHI: begin
                mem_we    = 1'b1;
                mem_waddr = r_hi;
                mem_wdata = r_rd_a;
                if (idx_plus2 < {1'b0, r_hi}) begin
                    // advance both pointers toward the middle
                    n_idx   = r_idx + AW'(1);
                    n_hi    = r_hi - AW'(1);
                    n_state = S_REV_RD;
                end else begin
                    n_out.data    = '0;
                    n_out.found   = 1'b0;
                    n_out.status  = ST_OK;
                    n_out.entries = to_entries(r_count);
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_hi  <= n_hi;
        r_key <= n_key;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re_a) begin
            r_rd_a <= r_mem[mem_addr_a];
        end
        if (mem_re_b) begin
            r_rd_b <= r_mem[mem_addr_b];
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_rev_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REV_RD || r_state == S_REV_WLO || r_state == S_REV_WHI)
        |-> (r_idx < r_hi))
        else $error("reverse pointers crossed");

    a_push_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.func == OP_PUSH && r_count != CW'(DEPTH))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the stack");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.func == OP_POP && r_count != '0)
        |=> (r_count == $past(r_count) - CW'(1)))
        else $error("pop did not shrink the stack");

    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_out_valid)
        else $error("result pending while sequencer busy");

endmodule

/* sim/tb_lifo_stack_search_reverse.sv */
// ----------------------------------------------------------------------------
// tb_lifo_stack_search_reverse
// Self-checking bench for the LIFO stack with search and reverse: a shadow
// stack predicts every result, a clocked driver and monitor run the
// valid/ready handshakes under changing idle rates and a long result stall.
// ----------------------------------------------------------------------------
module tb_lifo_stack_search_reverse;
    import lssr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1000;
    localparam int STALL_LIMIT  = 20000;      // cycles with no handshake at all
    localparam int DRAIN_CYCLES = 2 * DEPTH + 20;
    localparam int HOLD_AT      = 60;         // result count that starts the long stall
    localparam int HOLD_CYCLES  = 400;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     o_ready;
    t_request i_req   = '0;
    logic     o_valid;
    logic     i_ready = 1'b0;
    t_result  o_res;

    lifo_stack_search_reverse dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_res)
    );

    initial forever #5 i_clk = ~i_clk;

    // Stimulus and expectations
    t_request           pending_requests[$];
    t_result            expected_results[$];
    logic signed [31:0] key_pool[$];          // recently pushed words, for search hits
    int                 planned_items = 0;    // requests that the block acts on
    int                 total_requests = 0;

    // Shadow stack, index 0 at the bottom
    logic signed [31:0] shadow_words[DEPTH];
    int                 shadow_count = 0;
    int                 peak_count = 0;

    // Progress and tallies
    int sent_count    = 0;
    int result_count  = 0;
    int fail_count    = 0;
    int full_refusals = 0;
    int empty_reads   = 0;
    int search_hits   = 0;
    int stall_cycles  = 0;
    int hold_cnt      = 0;
    logic hold_armed  = 1'b1;

    // Idle rates per phase: sender busy-ish first, then receiver, then both with no idle cycles.
    int send_idle_pct;
    int recv_idle_pct;

    always_comb begin
        if (sent_count < total_requests / 3) begin
            send_idle_pct = 30;
            recv_idle_pct = 87;
        end else if (sent_count < (2 * total_requests) / 3) begin
            send_idle_pct = 87;
            recv_idle_pct = 30;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // Advance the shadow stack by one request and queue the result it owes.
    task automatic step_shadow_stack(input t_request req);
        t_result            res;
        int                 lo;
        int                 hi;
        logic signed [31:0] swap_word;
        res = '0;
        case (req.func)
            OP_PUSH: begin
                if (shadow_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_words[shadow_count] = req.value;
                    shadow_count++;
                end
            end
            OP_POP: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    shadow_count--;
                    res.data = shadow_words[shadow_count];
                end
            end
            OP_PEEK: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.data = shadow_words[shadow_count - 1];
                end
            end
            OP_SEARCH: begin
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_words[i] == req.value) begin
                        res.found = 1'b1;
                    end
                end
            end
            OP_REVERSE: begin
                lo = 0;
                hi = shadow_count - 1;
                while (lo < hi) begin
                    swap_word        = shadow_words[lo];
                    shadow_words[lo] = shadow_words[hi];
                    shadow_words[hi] = swap_word;
                    lo++;
                    hi--;
                end
            end
            default: ;  // unused codes leave the stack alone
        endcase
        res.entries = EW'(shadow_count);
        if (shadow_count > peak_count) begin
            peak_count = shadow_count;
        end
        expected_results.push_back(res);
    endtask

    function automatic void queue_request(input logic [2:0] func,
                                          input logic signed [31:0] value);
        t_request req;
        req.func  = func;
        req.value = value;
        pending_requests.push_back(req);
        if (func <= OP_REVERSE) begin
            planned_items++;
        end
        if (func == OP_PUSH) begin
            key_pool.push_back(value);
            if (key_pool.size() > 16) begin
                void'(key_pool.pop_front());
            end
        end
    endfunction

    // Mix extremes and a few small values in, so duplicates and search hits occur.
    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0;
            3:       return -32'sd1;
            4, 5:    return 32'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_key();
        if (key_pool.size() > 0 && $urandom_range(1) == 1) begin
            return key_pool[$urandom_range(key_pool.size() - 1)];
        end
        return pick_word();
    endfunction

    // ------------------------------------------------------------------------
    // Driver: hold the request until accepted, then predict it and load the
    // next one, or drop valid for an idle cycle.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_req   <= '0;
        end else begin
            if (i_valid && o_ready) begin
                step_shadow_stack(i_req);
                sent_count <= sent_count + 1;
            end
            if (!i_valid || o_ready) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_req   <= pending_requests.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result exp_res;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                result_count <= result_count + 1;
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: data %0d status %0d",
                           o_res.data, o_res.status);
                    fail_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (o_res.data !== exp_res.data) begin
                        $error("data mismatch: expected %0d, actual %0d",
                               exp_res.data, o_res.data);
                        fail_count++;
                    end
                    if (o_res.found !== exp_res.found) begin
                        $error("found mismatch: expected %0d, actual %0d",
                               exp_res.found, o_res.found);
                        fail_count++;
                    end
                    if (o_res.status !== exp_res.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               exp_res.status, o_res.status);
                        fail_count++;
                    end
                    if (o_res.entries !== exp_res.entries) begin
                        $error("entries mismatch: expected %0d, actual %0d",
                               exp_res.entries, o_res.entries);
                        fail_count++;
                    end
                    if (exp_res.status == ST_FULL) full_refusals++;
                    if (exp_res.status == ST_EMPTY) empty_reads++;
                    if (exp_res.found) search_hits++;
                end
            end
            // Ready is a fresh draw every cycle; hold it low through the long stall.
            i_ready <= (hold_cnt == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Long receiver stall, once: the sender keeps offering, so the block's
    // result slot fills and its input stalls behind it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt   <= 0;
            hold_armed <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end else if (hold_armed && result_count == HOLD_AT) begin
            hold_cnt   <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
    end

    // Watchdog: count cycles in which neither channel moves anything.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        int   random_start;
        int   mode;
        int   len;
        int   pick;
        logic timed_out;

        // Directed: empty-stack corner cases, unused codes, extremes.
        queue_request(OP_POP, 32'sd0);
        queue_request(OP_PEEK, 32'sd0);
        queue_request(OP_SEARCH, 32'sd0);
        queue_request(OP_REVERSE, 32'sd0);
        queue_request(3'd5, 32'sh5555_5555);
        queue_request(3'd6, 32'shaaaa_aaaa);
        queue_request(3'd7, -32'sd1);
        queue_request(OP_PUSH, 32'sh7fff_ffff);
        queue_request(OP_REVERSE, 32'sd0);          // single entry stays put
        queue_request(OP_PEEK, 32'sd0);
        queue_request(OP_PUSH, 32'sh8000_0000);
        queue_request(OP_PUSH, 32'sd0);
        queue_request(OP_PUSH, -32'sd1);
        queue_request(OP_SEARCH, -32'sd1);
        queue_request(OP_SEARCH, 32'sh8000_0000);
        queue_request(OP_SEARCH, 32'sd12345);
        queue_request(OP_REVERSE, 32'sd0);
        queue_request(OP_PEEK, 32'sd0);
        queue_request(3'd7, 32'sd0);
        queue_request(OP_POP, 32'sd0);
        queue_request(OP_POP, 32'sd0);
        queue_request(OP_POP, 32'sd0);
        queue_request(OP_POP, 32'sd0);
        queue_request(OP_POP, 32'sd0);              // empty again

        // Fill to the top, refuse a push, then search, reverse and drain.
        random_start = planned_items;
        for (int i = 0; i < DEPTH; i++) queue_request(OP_PUSH, pick_word());
        queue_request(OP_PUSH, pick_word());
        queue_request(OP_SEARCH, pick_key());
        queue_request(OP_REVERSE, 32'sd0);
        queue_request(OP_PEEK, 32'sd0);
        for (int i = 0; i <= DEPTH; i++) queue_request(OP_POP, 32'sd0);

        // Random sequences: push and pop bursts to reach both ends, mixed
        // traffic in between, and a little noise with every code.
        while (planned_items - random_start < RANDOM_ITEMS) begin
            mode = $urandom_range(9);
            if (mode <= 2) begin
                len = $urandom_range(1, DEPTH + 4);
                for (int i = 0; i < len; i++) queue_request(OP_PUSH, pick_word());
            end else if (mode <= 4) begin
                len = $urandom_range(1, DEPTH + 4);
                for (int i = 0; i < len; i++) begin
                    queue_request(($urandom_range(7) == 0) ? OP_PEEK : OP_POP, $urandom);
                end
            end else if (mode <= 8) begin
                len = $urandom_range(8, 32);
                for (int i = 0; i < len; i++) begin
                    pick = $urandom_range(99);
                    if (pick < 30)      queue_request(OP_PUSH, pick_word());
                    else if (pick < 50) queue_request(OP_POP, $urandom);
                    else if (pick < 65) queue_request(OP_PEEK, $urandom);
                    else if (pick < 90) queue_request(OP_SEARCH, pick_key());
                    else                queue_request(OP_REVERSE, $urandom);
                end
            end else begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) queue_request(3'($urandom_range(7)), $urandom);
            end
        end
        total_requests = pending_requests.size();

        // Hold reset at the start, then release it for good.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to go out and every result to come back.
        timed_out = 1'b0;
        while (!timed_out && !(sent_count == total_requests && expected_results.size() == 0))
        begin
            @(posedge i_clk);
            timed_out = (stall_cycles >= STALL_LIMIT);
        end

        // Let any stray result show up before judging.
        if (!timed_out) begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
        end

        if (timed_out) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("lifo_stack_search_reverse test failed");
        end else begin
            $display("Ran %0d requests, %0d results; stack peaked at %0d of %0d entries.",
                     total_requests, result_count, peak_count, DEPTH);
            $display("Saw %0d refused pushes, %0d empty reads, %0d search hits, %0d errors.",
                     full_refusals, empty_reads, search_hits, fail_count);
            if (fail_count == 0) begin
                $display("lifo_stack_search_reverse test passed");
            end else begin
                $display("lifo_stack_search_reverse test failed");
            end
        end
        $finish;
    end

endmodule
